### rtl/wdec_pkg.sv
`default_nettype none

package wdec_pkg;

    localparam int BUFFER_DEPTH = 300;
    localparam int TIMER_BITS   = 14;

    localparam int COUNT_W   = 16;
    localparam int PULSE_W   = COUNT_W - 1;
    localparam int SLOT_W    = $clog2(BUFFER_DEPTH + 1);
    localparam int ADDR_W    = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int SLOT_NUM_W = 9;

    localparam logic [TIMER_BITS-1:0] WINDOW_RESET = TIMER_BITS'(14'h249F);
    localparam logic [COUNT_W-1:0]    COUNT_MAX    = {COUNT_W{1'b1}};
    localparam logic [SLOT_W-1:0]     SLOT_LAST    = SLOT_W'(BUFFER_DEPTH);

    // one closed window waiting for the store read-back
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic [COUNT_W-1:0] rain;
        logic              full;
    } wdec_rec_t;

    // write port into the pulse store
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PULSE_W-1:0] data;
    } wdec_wr_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_W'(1);
    endfunction

endpackage

`default_nettype wire

### rtl/wdec_counter.sv
`default_nettype none

module wdec_counter
    import wdec_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [TIMER_BITS-1:0] cfg_wdata,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  wind_level,
    input  wire logic                  rain_level,
    input  wire logic [TIMER_BITS-1:0] time_now,
    input  wire logic                  rec_take,
    output wdec_rec_t                  rec,
    output wdec_wr_t                   wr
);

    logic [TIMER_BITS-1:0] window_ticks_reg;
    logic                  prev_wind_reg,  prev_wind_next;
    logic                  prev_rain_reg,  prev_rain_next;
    logic                  seen_reg,       seen_next;
    logic [COUNT_W-1:0]    wind_cnt_reg,   wind_cnt_next;
    logic [COUNT_W-1:0]    rain_cnt_reg,   rain_cnt_next;
    logic [TIMER_BITS-1:0] start_reg,      start_next;
    logic [SLOT_W-1:0]     slot_reg,       slot_next;
    wdec_rec_t             rec_reg,        rec_next;

    logic                  fire;
    logic                  active;
    logic                  close;
    logic [COUNT_W-1:0]    wind_inc;
    logic [COUNT_W-1:0]    rain_inc;
    logic [TIMER_BITS-1:0] elapsed;

    assign in_ready = !rec_reg.valid || rec_take;
    assign fire     = in_valid && in_ready;
    assign active   = slot_reg < SLOT_LAST;

    assign wind_inc = (wind_level != prev_wind_reg) ? sat_inc(wind_cnt_reg) : wind_cnt_reg;
    assign rain_inc = (rain_level != prev_rain_reg) ? sat_inc(rain_cnt_reg) : rain_cnt_reg;
    // wraps modulo the timer width
    assign elapsed  = time_now - start_reg;
    assign close    = fire && active && seen_reg && (elapsed >= window_ticks_reg);

    always_comb
    begin
        prev_wind_next = prev_wind_reg;
        prev_rain_next = prev_rain_reg;
        seen_next      = seen_reg;
        wind_cnt_next  = wind_cnt_reg;
        rain_cnt_next  = rain_cnt_reg;
        start_next     = start_reg;
        slot_next      = slot_reg;
        if (fire && active)
        begin
            prev_wind_next = wind_level;
            prev_rain_next = rain_level;
            if (!seen_reg)
            begin
                // first item only latches levels and opens the window
                seen_next  = 1'b1;
                start_next = time_now;
            end
            else
            begin
                wind_cnt_next = wind_inc;
                rain_cnt_next = rain_inc;
                if (close)
                begin
                    wind_cnt_next = '0;
                    start_next    = time_now;
                    slot_next     = slot_reg + SLOT_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        rec_next = rec_reg;
        if (rec_take)
        begin
            rec_next.valid = 1'b0;
        end
        if (close)
        begin
            rec_next.valid = 1'b1;
            rec_next.slot  = slot_reg;
            rec_next.rain  = rain_inc;
            rec_next.full  = (slot_reg + SLOT_W'(1)) == SLOT_LAST;
        end
    end

    assign wr.en   = close;
    assign wr.addr = slot_reg[ADDR_W-1:0];
    assign wr.data = wind_inc[COUNT_W-1:1];
    assign rec     = rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ticks_reg <= WINDOW_RESET;
            prev_wind_reg    <= 1'b0;
            prev_rain_reg    <= 1'b0;
            seen_reg         <= 1'b0;
            wind_cnt_reg     <= '0;
            rain_cnt_reg     <= '0;
            start_reg        <= '0;
            slot_reg         <= '0;
            rec_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_ticks_reg <= cfg_wdata;
            end
            prev_wind_reg <= prev_wind_next;
            prev_rain_reg <= prev_rain_next;
            seen_reg      <= seen_next;
            wind_cnt_reg  <= wind_cnt_next;
            rain_cnt_reg  <= rain_cnt_next;
            start_reg     <= start_next;
            slot_reg      <= slot_next;
            rec_reg       <= rec_next;
        end
    end

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_LAST)
        else $error("slot index beyond buffer depth");

    a_rec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rec_reg.valid && !rec_take |=> rec_reg.valid && $stable(rec_reg.slot))
        else $error("pending record lost or changed");

    a_write_rec: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |=> rec_reg.valid && (rec_reg.slot == $past(slot_reg)))
        else $error("store write without matching record");

    a_full_last: assert property (@(posedge clk) disable iff (!rst_n)
        rec_reg.valid && rec_reg.full |-> slot_reg == SLOT_LAST)
        else $error("full flag on a record that is not the last");

endmodule

`default_nettype wire

### rtl/wdec_store.sv
`default_nettype none

module wdec_store
    import wdec_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire wdec_wr_t               wr,
    input  wire wdec_rec_t              rec,
    output logic                        rec_take,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [SLOT_NUM_W-1:0]       slot_number,
    output logic [PULSE_W-1:0]          wind_pulses,
    output logic [COUNT_W-1:0]          rain_total,
    output logic                        buffer_full
);

    logic [PULSE_W-1:0]  mem [BUFFER_DEPTH];
    logic [PULSE_W-1:0]  rd_reg;
    logic                out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]   slot_reg;
    logic [COUNT_W-1:0]  rain_reg;
    logic                full_reg;

    // a record moves on when the output register is free or being emptied
    assign rec_take       = rec.valid && (!out_valid_reg || out_ready);
    assign out_valid_next = rec_take ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        // entry was written when the record was stored, before it can be taken
        if (rec_take)
        begin
            rd_reg   <= mem[rec.slot[ADDR_W-1:0]];
            slot_reg <= rec.slot;
            rain_reg <= rec.rain;
            full_reg <= rec.full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign slot_number = SLOT_NUM_W'(slot_reg);
    assign wind_pulses = rd_reg;
    assign rain_total  = rain_reg;
    assign buffer_full = full_reg;

    a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
        rec_take |=> out_valid_reg)
        else $error("record taken but output not loaded");

    a_no_write_read_clash: assert property (@(posedge clk) disable iff (!rst_n)
        rec_take && wr.en |-> wr.addr != rec.slot[ADDR_W-1:0])
        else $error("store read and write hit the same slot");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> $stable(slot_reg) && $stable(rd_reg))
        else $error("stalled record changed");

endmodule

`default_nettype wire

### rtl/windowed_dual_edge_counter.sv
`default_nettype none

// Counts level changes on the wind and rain pins, one sample item per clock
// while in_ready is high. The first item after reset only latches both levels
// and opens the first window. When time_now has moved on by window_ticks or
// more (modulo the 14-bit timer) the window closes: half the wind count goes
// into the next slot of a 300-entry store and one record leaves with the slot,
// that value read back from the store, the saturating rain total and a full
// flag on the last slot. A record is held in the record stage and is loaded
// into the output register together with the store read once that register
// is free or being emptied. An item is taken every cycle while out_ready is
// high; a record held by a stalled output blocks new items only once the
// record stage is also occupied. After the last slot is filled every item
// taken is ignored. The store needs no clearing after reset. window_ticks
// resets to 9375 and is written through cfg_we/cfg_wdata; the user must do
// so only while the block is idle, as the block does not enforce it.

module windowed_dual_edge_counter
    import wdec_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [TIMER_BITS-1:0] cfg_wdata,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  wind_level,
    input  wire logic                  rain_level,
    input  wire logic [TIMER_BITS-1:0] time_now,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [SLOT_NUM_W-1:0]      slot_number,
    output logic [PULSE_W-1:0]         wind_pulses,
    output logic [COUNT_W-1:0]         rain_total,
    output logic                       buffer_full
);

    wdec_rec_t rec;
    wdec_wr_t  wr;
    logic      rec_take;

    wdec_counter u_counter (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .wind_level (wind_level),
        .rain_level (rain_level),
        .time_now   (time_now),
        .rec_take   (rec_take),
        .rec        (rec),
        .wr         (wr)
    );

    wdec_store u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr          (wr),
        .rec         (rec),
        .rec_take    (rec_take),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .slot_number (slot_number),
        .wind_pulses (wind_pulses),
        .rain_total  (rain_total),
        .buffer_full (buffer_full)
    );

endmodule

`default_nettype wire
